// ===== rtl/core/lfu_fifo_page_replacement_assert.svh =====
// assertion helpers for the lfu page replacement block
`ifndef LFU_FIFO_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_FIFO_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked only out of reset
`define LFU_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lfu assertion failed: same-cycle check");

// next-cycle implication, checked only out of reset
`define LFU_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lfu assertion failed: next-cycle check");

`else

`define LFU_ASSERT_IMP(name, clk, rstn, ante, cons)
`define LFU_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/lfu_fpr_pkg.sv =====
package lfu_fpr_pkg;

  // fixed field widths
  localparam int PAGE_W      = 16;
  localparam int NUM_W       = 4;
  localparam int FIDX_W      = 3;
  localparam int STAMP_W     = 32;
  localparam int FAULT_W     = 32;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_FIELD_W = 1 + FIDX_W + 1 + PAGE_W + FAULT_W;

  // frame count after reset
  localparam logic [NUM_W-1:0] NUM_FRAMES_RST = NUM_W'(3);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT_SCAN,
    ST_VIC_SCAN,
    ST_UPDATE
  } state_t;

  // operations of the shared compare unit
  typedef enum logic {
    CMP_PAGE_EQ,
    CMP_LFU_LESS
  } cmp_op_t;

  // frame store write control
  typedef struct packed {
    logic en;    // write the use count
    logic load;  // also load page, arrival stamp and valid mark
  } frame_wr_ctl_t;

endpackage

// ===== rtl/core/lfu_fpr_cmp.sv =====
module lfu_fpr_cmp #(
  parameter int COUNT_BITS = 16
) (
  input  lfu_fpr_pkg::cmp_op_t                op,
  input  logic                                a_valid,
  input  logic [lfu_fpr_pkg::PAGE_W-1:0]      a_page,
  input  logic [COUNT_BITS-1:0]               a_uses,
  input  logic [lfu_fpr_pkg::STAMP_W-1:0]     a_arrival,
  input  logic [lfu_fpr_pkg::PAGE_W-1:0]      b_page,
  input  logic [COUNT_BITS-1:0]               b_uses,
  input  logic [lfu_fpr_pkg::STAMP_W-1:0]     b_arrival,
  output logic                                is_true
);
  import lfu_fpr_pkg::*;

  logic uses_lt;
  logic uses_eq;
  logic arr_lt;

  // one magnitude compare on counts, one on stamps
  assign uses_lt = a_uses < b_uses;
  assign uses_eq = a_uses == b_uses;
  assign arr_lt  = a_arrival < b_arrival;

  // page match on a filled frame, or frame a is the better victim
  always_comb begin
    case (op)
      CMP_PAGE_EQ:  is_true = a_valid && (a_page == b_page);
      CMP_LFU_LESS: is_true = uses_lt || (uses_eq && arr_lt);
      default:      is_true = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/lfu_fpr_store.sv =====
module lfu_fpr_store #(
  parameter int MAX_FRAMES = 8,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [IDX_W-1:0]                    idx,
  input  logic [IDX_W-1:0]                    rd_idx,
  input  lfu_fpr_pkg::frame_wr_ctl_t          wr_ctl,
  input  logic [lfu_fpr_pkg::PAGE_W-1:0]      wr_page,
  input  logic [COUNT_BITS-1:0]               wr_uses,
  input  logic [lfu_fpr_pkg::STAMP_W-1:0]     wr_arrival,
  output logic                                rd_valid,
  output logic [lfu_fpr_pkg::PAGE_W-1:0]      rd_page,
  output logic [COUNT_BITS-1:0]               rd_uses,
  output logic [lfu_fpr_pkg::STAMP_W-1:0]     rd_arrival
);
  import lfu_fpr_pkg::*;

  logic [PAGE_W-1:0]     page_mem [MAX_FRAMES];
  logic [COUNT_BITS-1:0] uses_mem [MAX_FRAMES];
  logic [STAMP_W-1:0]    arr_mem  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r;

  // valid marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.en && wr_ctl.load) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // frame contents, only read once the frame is valid
  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      uses_mem[idx] <= wr_uses;
      if (wr_ctl.load) begin
        page_mem[idx] <= wr_page;
        arr_mem[idx]  <= wr_arrival;
      end
    end
  end

  // registered read at the pointer's next value, so data lines up with idx
  always_ff @(posedge clk) begin
    rd_page    <= page_mem[rd_idx];
    rd_uses    <= uses_mem[rd_idx];
    rd_arrival <= arr_mem[rd_idx];
  end

  assign rd_valid = valid_r[idx];

endmodule

// ===== rtl/core/lfu_fifo_page_replacement.sv =====
// LFU page replacer with oldest-first tie-break. Each input transfer carries one page
// number; one result transfer follows with hit/fault, the frame used, the evicted page
// and the running fault total. A single compare unit visits one frame per cycle, first
// searching for the page and then, when all active frames are full, scanning for the
// least-used, oldest frame. With n active frames (cfg_wr_data clamped to 1..MAX_FRAMES),
// a hit ends the search at its frame, a miss that fills an empty frame searches all n
// frames, and a miss that evicts then scans all n for a victim. The input is not ready
// while an item is in flight. The result sits in an output register, so the next page is
// taken while that result waits. cfg_wr_en may be pulsed only while the block is idle.
`include "lfu_fifo_page_replacement_assert.svh"

module lfu_fifo_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: number of frames in use
  input  logic                                 cfg_wr_en,
  input  logic [lfu_fpr_pkg::NUM_W-1:0]        cfg_wr_data,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lfu_fpr_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] page
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lfu_fpr_pkg::OUT_DATA_W-1:0]   out_tdata   // [0] hit, [3:1] frame_index,
                                                           // [4] evicted_valid,
                                                           // [20:5] evicted_page,
                                                           // [52:21] fault_total,
                                                           // [55:53] zero
);
  import lfu_fpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // sequencer and item registers
  state_t                state_r, state_nxt;
  logic [PAGE_W-1:0]     page_r, page_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  hit_r, hit_nxt;
  logic                  ev_r, ev_nxt;
  // best victim so far
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_uses_r, best_uses_nxt;
  logic [STAMP_W-1:0]    best_arr_r, best_arr_nxt;
  logic [PAGE_W-1:0]     best_page_r, best_page_nxt;
  // block state
  logic [NUM_W-1:0]      num_frames_r;
  logic [CNT_W-1:0]      filled_r, filled_nxt;
  logic [STAMP_W-1:0]    stamp_r, stamp_nxt;
  logic [FAULT_W-1:0]    fault_r, fault_nxt;
  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // frame store and compare unit wiring
  frame_wr_ctl_t         wr_ctl;
  logic [COUNT_BITS-1:0] wr_uses;
  logic                  rd_valid;
  logic [PAGE_W-1:0]     rd_page;
  logic [COUNT_BITS-1:0] rd_uses;
  logic [STAMP_W-1:0]    rd_arrival;
  cmp_op_t               cmp_op;
  logic                  cmp_true;

  // helpers
  logic [CNT_W-1:0]      n_act;
  logic                  last_frame;
  logic                  out_free;
  logic [IDX_W+2:0]      slot_ext;
  logic [FAULT_W-1:0]    fault_new;
  logic [PAGE_W-1:0]     ev_page;

  lfu_fpr_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .idx        (idx_r),
    .rd_idx     (idx_nxt),
    .wr_ctl     (wr_ctl),
    .wr_page    (page_r),
    .wr_uses    (wr_uses),
    .wr_arrival (stamp_r),
    .rd_valid   (rd_valid),
    .rd_page    (rd_page),
    .rd_uses    (rd_uses),
    .rd_arrival (rd_arrival)
  );

  lfu_fpr_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .op        (cmp_op),
    .a_valid   (rd_valid),
    .a_page    (rd_page),
    .a_uses    (rd_uses),
    .a_arrival (rd_arrival),
    .b_page    ((cmp_op == CMP_PAGE_EQ) ? page_r : best_page_r),
    .b_uses    (best_uses_r),
    .b_arrival (best_arr_r),
    .is_true   (cmp_true)
  );

  // active frame count: zero acts as one, clamp at the frame array size
  always_comb begin
    if (num_frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(num_frames_r) > MAX_FRAMES) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(num_frames_r);
    end
  end

  assign last_frame = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;
  assign out_free   = !out_valid_r || out_tready;
  assign slot_ext   = {3'b000, idx_r};
  assign fault_new  = (!hit_r && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;
  assign ev_page    = ev_r ? best_page_r : '0;

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    ev_nxt        = ev_r;
    best_idx_nxt  = best_idx_r;
    best_uses_nxt = best_uses_r;
    best_arr_nxt  = best_arr_r;
    best_page_nxt = best_page_r;
    filled_nxt    = filled_r;
    stamp_nxt     = stamp_r;
    fault_nxt     = fault_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_ctl        = '0;
    wr_uses       = '0;
    cmp_op        = CMP_PAGE_EQ;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          page_nxt  = in_tdata[PAGE_W-1:0];
          n_nxt     = n_act;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          ev_nxt    = 1'b0;
          state_nxt = ST_HIT_SCAN;
        end
      end

      // look for the page, one frame per cycle
      ST_HIT_SCAN: begin
        cmp_op = CMP_PAGE_EQ;
        if (cmp_true) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_UPDATE;
        end else if (last_frame) begin
          if (filled_r < n_r) begin
            idx_nxt   = IDX_W'(filled_r);
            state_nxt = ST_UPDATE;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_VIC_SCAN;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // least used, then earliest loaded; first frame seeds the best
      ST_VIC_SCAN: begin
        cmp_op = CMP_LFU_LESS;
        if ((idx_r == '0) || cmp_true) begin
          best_idx_nxt  = idx_r;
          best_uses_nxt = rd_uses;
          best_arr_nxt  = rd_arrival;
          best_page_nxt = rd_page;
        end
        if (last_frame) begin
          idx_nxt   = best_idx_nxt;
          ev_nxt    = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // write the frame and post the result once the output register frees
      ST_UPDATE: begin
        if (out_free) begin
          wr_ctl.en   = 1'b1;
          wr_ctl.load = !hit_r;
          if (hit_r && (rd_uses != '1)) begin
            wr_uses = rd_uses + COUNT_BITS'(1);
          end else if (hit_r) begin
            wr_uses = rd_uses;
          end else begin
            wr_uses = '0;
          end
          if (!hit_r && !ev_r) begin
            filled_nxt = filled_r + CNT_W'(1);
          end
          if (stamp_r != '1) begin
            stamp_nxt = stamp_r + STAMP_W'(1);
          end
          fault_nxt     = fault_new;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W - OUT_FIELD_W)'(0), fault_new, ev_page, ev_r,
                           slot_ext[FIDX_W-1:0], hit_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NUM_FRAMES_RST;
      filled_r     <= '0;
      stamp_r      <= '0;
      fault_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_frames_r <= cfg_wr_data;
      end
      filled_r    <= filled_nxt;
      stamp_r     <= stamp_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    ev_r        <= ev_nxt;
    best_idx_r  <= best_idx_nxt;
    best_uses_r <= best_uses_nxt;
    best_arr_r  <= best_arr_nxt;
    best_page_r <= best_page_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // fill count never passes the frame array size
  `LFU_ASSERT_IMP(a_filled_range, clk, rst_n, 1'b1, 32'(filled_r) <= MAX_FRAMES)
  // an eviction is always a fault
  `LFU_ASSERT_IMP(a_evict_is_miss, clk, rst_n, out_valid_r && out_data_r[4], !out_data_r[0])
  // accepted item blocks the input until its result is posted
  `LFU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // fault total only moves up
  `LFU_ASSERT_NXT(a_fault_monotonic, clk, rst_n, 1'b1, fault_r >= $past(fault_r))

endmodule
